>>> hdl/abkf_pkg.sv
// shared types, constants and saturation helpers for the angle/bias kalman filter
package abkf_pkg;

    localparam logic        C_OP_UPDATE = 1'b0;
    localparam logic        C_OP_LOAD   = 1'b1;

    localparam logic [1:0]  C_REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0]  C_REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0]  C_REG_MEAS_NOISE  = 2'd2;

    localparam logic [23:0] C_RST_ANGLE_NOISE = 24'd16777;
    localparam logic [23:0] C_RST_BIAS_NOISE  = 24'd50332;
    localparam logic [23:0] C_RST_MEAS_NOISE  = 24'd503316;

    localparam logic signed [39:0] C_COV_ONE = 40'sd16777216;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_W_ANG,
        S_W_D,
        S_W_AA,
        S_W_BB,
        S_W_K0,
        S_W_K1,
        S_CORR,
        S_W_CA,
        S_W_CB,
        S_W_BA,
        S_W_BB2,
        S_W_AB,
        S_W_AA2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic               sh24;
        logic signed [49:0] a;
        logic signed [49:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic signed [39:0] num;
        logic signed [40:0] den;
    } t_div_req;

    function automatic logic signed [31:0] f_sat32(input logic signed [51:0] v);
        if (v > 52'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [39:0] f_sat40(input logic signed [51:0] v);
        if (v > 52'sd549755813887) begin
            return 40'sh7fffffffff;
        end else if (v < -52'sd549755813888) begin
            return 40'sh8000000000;
        end else begin
            return v[39:0];
        end
    endfunction

endpackage

>>> hdl/angle_bias_kalman_filter_unit.sv
// angle/gyro-bias kalman filter top level: sequencer, state and shared units
//
//  channel  dir  handshake                 payload
//  input    in   i_valid / o_ready         i_opcode, i_angle_measured, i_gyro_rate, i_time_step
//  output   out  o_valid / i_ready         o_angle_estimate, o_corrected_rate
//  config   in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  load skips the arithmetic and goes straight to the done state; update runs
//  ten products on the shared 50x17 multiplier and two gains on the
//  bit-serial divider, one after another (both gains are skipped when the
//  innovation variance is not positive).
//  o_ready is high only while the sequencer is idle; the output register lets
//  a new beat in while a result still waits. reset is synchronous, active low,
//  and restores the filter state and noise registers; config is always ready.
module angle_bias_kalman_filter_unit
    import abkf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic signed [31:0] i_angle_measured,
    input  logic signed [31:0] i_gyro_rate,
    input  logic [15:0]        i_time_step,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_angle_estimate,
    output logic signed [31:0] o_corrected_rate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    t_state             r_state, n_state;
    logic signed [31:0] r_angle, n_angle;
    logic signed [31:0] r_bias, n_bias;
    logic signed [31:0] r_last, n_last;
    logic signed [39:0] r_aa, n_aa;
    logic signed [39:0] r_ab, n_ab;
    logic signed [39:0] r_ba, n_ba;
    logic signed [39:0] r_bb, n_bb;
    logic [23:0]        r_qa, n_qa;
    logic [23:0]        r_qb, n_qb;
    logic [23:0]        r_rn, n_rn;
    logic signed [31:0] r_meas, n_meas;
    logic signed [31:0] r_gyro, n_gyro;
    logic [15:0]        r_dt, n_dt;
    logic signed [40:0] r_s, n_s;
    logic signed [39:0] r_k0, n_k0;
    logic signed [39:0] r_k1, n_k1;
    logic signed [32:0] r_y, n_y;
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_oang, n_oang;
    logic signed [31:0] r_orate, n_orate;

    t_mul_req           w_mreq;
    t_div_req           w_dreq;
    logic               w_mdone;
    logic signed [47:0] w_mres;
    logic               w_ddone;
    logic signed [39:0] w_quo;

    logic signed [31:0] w_rate;
    logic signed [51:0] w_inner;
    logic signed [51:0] w_sum_s;
    logic signed [51:0] w_yv;
    logic signed [49:0] w_dt50;

    abkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    assign o_ready          = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_ovalid;
    assign o_angle_estimate = r_oang;
    assign o_corrected_rate = r_orate;

    always_comb begin
        n_state  = r_state;
        n_angle  = r_angle;
        n_bias   = r_bias;
        n_last   = r_last;
        n_aa     = r_aa;
        n_ab     = r_ab;
        n_ba     = r_ba;
        n_bb     = r_bb;
        n_qa     = r_qa;
        n_qb     = r_qb;
        n_rn     = r_rn;
        n_meas   = r_meas;
        n_gyro   = r_gyro;
        n_dt     = r_dt;
        n_s      = r_s;
        n_k0     = r_k0;
        n_k1     = r_k1;
        n_y      = r_y;
        n_ovalid = r_ovalid && !i_ready;
        n_oang   = r_oang;
        n_orate  = r_orate;
        w_mreq   = '0;
        w_dreq   = '0;

        w_dt50  = 50'({1'b0, r_dt});
        w_rate  = f_sat32(52'(r_gyro) - 52'(r_bias));
        w_inner = 52'(w_mres) - 52'(r_ab) - 52'(r_ba) + $signed({28'b0, r_qa});
        w_sum_s = 52'(r_aa) + $signed({28'b0, r_rn});
        w_yv    = 52'(r_meas) - 52'(r_angle);

        if (i_cfg_valid) begin
            case (i_cfg_index)
                C_REG_ANGLE_NOISE: n_qa = i_cfg_data;
                C_REG_BIAS_NOISE:  n_qb = i_cfg_data;
                C_REG_MEAS_NOISE:  n_rn = i_cfg_data;
                default:           n_qa = r_qa;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_meas = i_angle_measured;
                    n_gyro = i_gyro_rate;
                    n_dt   = i_time_step;
                    if (i_opcode == C_OP_LOAD) begin
                        n_angle = i_angle_measured;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PRED;
                    end
                end
            end
            S_PRED: begin
                n_last = w_rate;
                w_mreq = '{start: 1'b1, sh24: 1'b0, a: w_dt50, b: 50'(w_rate)};
                n_state = S_W_ANG;
            end
            S_W_ANG: begin
                if (w_mdone) begin
                    n_angle = f_sat32(52'(r_angle) + 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b0, a: w_dt50, b: 50'(r_bb)};
                    n_state = S_W_D;
                end
            end
            S_W_D: begin
                if (w_mdone) begin
                    n_ab = f_sat40(52'(r_ab) - 52'(w_mres));
                    n_ba = f_sat40(52'(r_ba) - 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b0, a: w_dt50, b: w_inner[49:0]};
                    n_state = S_W_AA;
                end
            end
            S_W_AA: begin
                if (w_mdone) begin
                    n_aa = f_sat40(52'(r_aa) + 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b0, a: 50'({1'b0, r_qb}), b: w_dt50};
                    n_state = S_W_BB;
                end
            end
            S_W_BB: begin
                if (w_mdone) begin
                    n_bb = f_sat40(52'(r_bb) + 52'(w_mres));
                    n_s  = w_sum_s[40:0];
                    // non-positive innovation variance leaves both gains at zero
                    if (w_sum_s > 52'sd0) begin
                        w_dreq = '{start: 1'b1, num: r_aa, den: w_sum_s[40:0]};
                        n_state = S_W_K0;
                    end else begin
                        n_k0 = '0;
                        n_k1 = '0;
                        n_state = S_CORR;
                    end
                end
            end
            S_W_K0: begin
                if (w_ddone) begin
                    n_k0 = w_quo;
                    w_dreq = '{start: 1'b1, num: r_ba, den: r_s};
                    n_state = S_W_K1;
                end
            end
            S_W_K1: begin
                if (w_ddone) begin
                    n_k1 = w_quo;
                    n_state = S_CORR;
                end
            end
            S_CORR: begin
                n_y = w_yv[32:0];
                w_mreq = '{start: 1'b1, sh24: 1'b1, a: 50'(r_k0), b: w_yv[49:0]};
                n_state = S_W_CA;
            end
            S_W_CA: begin
                if (w_mdone) begin
                    n_angle = f_sat32(52'(r_angle) + 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b1, a: 50'(r_k1), b: 50'(r_y)};
                    n_state = S_W_CB;
                end
            end
            // posterior terms ordered so aa and ab are overwritten last
            S_W_CB: begin
                if (w_mdone) begin
                    n_bias = f_sat32(52'(r_bias) + 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b1, a: 50'(r_k1), b: 50'(r_aa)};
                    n_state = S_W_BA;
                end
            end
            S_W_BA: begin
                if (w_mdone) begin
                    n_ba = f_sat40(52'(r_ba) - 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b1, a: 50'(r_k1), b: 50'(r_ab)};
                    n_state = S_W_BB2;
                end
            end
            S_W_BB2: begin
                if (w_mdone) begin
                    n_bb = f_sat40(52'(r_bb) - 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b1, a: 50'(r_k0), b: 50'(r_ab)};
                    n_state = S_W_AB;
                end
            end
            S_W_AB: begin
                if (w_mdone) begin
                    n_ab = f_sat40(52'(r_ab) - 52'(w_mres));
                    w_mreq = '{start: 1'b1, sh24: 1'b1, a: 50'(r_k0), b: 50'(r_aa)};
                    n_state = S_W_AA2;
                end
            end
            S_W_AA2: begin
                if (w_mdone) begin
                    n_aa = f_sat40(52'(r_aa) - 52'(w_mres));
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oang   = r_angle;
                    n_orate  = r_last;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_angle  <= '0;
            r_bias   <= '0;
            r_last   <= '0;
            r_aa     <= C_COV_ONE;
            r_ab     <= '0;
            r_ba     <= '0;
            r_bb     <= C_COV_ONE;
            r_qa     <= C_RST_ANGLE_NOISE;
            r_qb     <= C_RST_BIAS_NOISE;
            r_rn     <= C_RST_MEAS_NOISE;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_angle  <= n_angle;
            r_bias   <= n_bias;
            r_last   <= n_last;
            r_aa     <= n_aa;
            r_ab     <= n_ab;
            r_ba     <= n_ba;
            r_bb     <= n_bb;
            r_qa     <= n_qa;
            r_qb     <= n_qb;
            r_rn     <= n_rn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meas  <= n_meas;
        r_gyro  <= n_gyro;
        r_dt    <= n_dt;
        r_s     <= n_s;
        r_k0    <= n_k0;
        r_k1    <= n_k1;
        r_y     <= n_y;
        r_oang  <= n_oang;
        r_orate <= n_orate;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("accepted beat did not start the sequencer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mdone && w_ddone))
        else $error("multiplier and divider finished together");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || i_ready)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("result not handed to the output register");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mreq.start || w_dreq.start) |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("arithmetic unit started outside an update");

endmodule

>>> hdl/abkf_mul.sv
// shared digit-serial multiplier: rounded, shifted and clamped signed product
module abkf_mul
    import abkf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    output logic               o_done,
    output logic signed [47:0] o_res
);

    logic         r_busy;
    logic         r_done;
    logic [1:0]   r_cnt;
    logic [49:0]  r_ma;
    logic [50:0]  r_mb;
    logic         r_neg;
    logic         r_sh24;
    logic [103:0] r_acc;

    logic [49:0]  w_ma;
    logic [49:0]  w_mb;
    logic [66:0]  w_part;
    logic [103:0] w_shift;
    logic [87:0]  w_mag;
    logic         w_over;
    logic [47:0]  w_clamp;

    always_comb begin
        w_ma = i_req.a[49] ? 50'(-i_req.a) : 50'(i_req.a);
        w_mb = i_req.b[49] ? 50'(-i_req.b) : 50'(i_req.b);
        w_part = 67'(r_ma) * 67'(r_mb[16:0]);
        case (r_cnt)
            2'd0:    w_shift = {37'b0, w_part};
            2'd1:    w_shift = {20'b0, w_part, 17'b0};
            2'd2:    w_shift = {3'b0, w_part, 34'b0};
            default: w_shift = '0;
        endcase
        w_mag = r_sh24 ? {8'b0, r_acc[103:24]} : r_acc[103:16];
        // negative side may reach one step further
        if (r_neg) begin
            w_over = (|w_mag[87:48]) | (w_mag[47] & (|w_mag[46:0]));
            w_clamp = w_over ? 48'h800000000000 : w_mag[47:0];
        end else begin
            w_over = |w_mag[87:47];
            w_clamp = w_over ? 48'h7fffffffffff : w_mag[47:0];
        end
        o_res = r_neg ? -$signed(w_clamp) : $signed(w_clamp);
        o_done = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma   <= w_ma;
            r_mb   <= {1'b0, w_mb};
            r_neg  <= i_req.a[49] ^ i_req.b[49];
            r_sh24 <= i_req.sh24;
            // rounding half preloaded into the accumulator
            r_acc  <= i_req.sh24 ? (104'd1 << 23) : (104'd1 << 15);
        end else if (r_busy) begin
            r_acc <= r_acc + w_shift;
            r_mb  <= r_mb >> 17;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier started while busy");

endmodule

>>> hdl/abkf_div.sv
// radix-2 restoring divider for the rounded q15.24 gain
module abkf_div
    import abkf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic signed [39:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_n;
    logic [40:0] r_rem;
    logic [40:0] r_d;
    logic        r_neg;

    logic [39:0] w_mnum;
    logic [41:0] w_trial;
    logic        w_ge;
    logic        w_over;
    logic [39:0] w_clamp;

    always_comb begin
        w_mnum  = i_req.num[39] ? 40'(-i_req.num) : 40'(i_req.num);
        w_trial = {r_rem, r_n[63]};
        w_ge    = w_trial >= {1'b0, r_d};
        if (r_neg) begin
            w_over  = (|r_n[63:40]) | (r_n[39] & (|r_n[38:0]));
            w_clamp = w_over ? 40'h8000000000 : r_n[39:0];
        end else begin
            w_over  = |r_n[63:39];
            w_clamp = w_over ? 40'h7fffffffff : r_n[39:0];
        end
        o_quo  = r_neg ? -$signed(w_clamp) : $signed(w_clamp);
        o_done = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // dividend is |num| << 24 plus half the divisor for rounding
            r_n   <= {w_mnum, 24'b0} + {24'b0, i_req.den[40:1]};
            r_rem <= '0;
            r_d   <= i_req.den[40:0];
            r_neg <= i_req.num[39];
        end else if (r_busy) begin
            r_rem <= w_ge ? 41'(w_trial - {1'b0, r_d}) : w_trial[40:0];
            r_n   <= {r_n[62:0], w_ge};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (!r_busy && i_req.den > 41'sd0))
        else $error("divider started while busy or with non-positive divisor");

endmodule

>>> tb/abkf_checker.sv
// checker for the angle/bias kalman filter: watches beats, predicts results and compares
`timescale 1ns / 100ps
module abkf_checker
    import abkf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic               i_opcode,
    input  logic signed [31:0] i_angle_measured,
    input  logic signed [31:0] i_gyro_rate,
    input  logic [15:0]        i_time_step,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_angle_estimate,
    input  logic signed [31:0] i_corrected_rate,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    logic signed [63:0] q_angle, q_bias, r_meas;
    logic signed [63:0] ang, bias, last_rate;
    logic signed [63:0] p_aa, p_ab, p_ba, p_bb;

    logic signed [31:0] angle_q[$];
    logic signed [31:0] rate_q[$];

    function automatic logic [127:0] f_mag(input logic signed [63:0] v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic signed [63:0] f_clamp(input logic neg, input logic [127:0] m,
                                                   input int w);
        logic [127:0] lim;
        lim = 128'd1 << (w - 1);
        if (neg) begin
            if (m > lim) m = lim;
            return -64'(m);
        end
        if (m > lim - 1) m = lim - 1;
        return 64'(m);
    endfunction

    function automatic logic signed [63:0] f_sat(input logic signed [63:0] v, input int w);
        return f_clamp(v < 0, f_mag(v), w);
    endfunction

    // exact product, rounded shift with ties away from zero
    function automatic logic signed [63:0] f_mulr(input logic signed [63:0] a,
                                                  input logic signed [63:0] b, input int sh);
        logic [127:0] m;
        m = f_mag(a) * f_mag(b);
        m = (m + (128'd1 << (sh - 1))) >> sh;
        return f_clamp((a < 0) != (b < 0), m, 48);
    endfunction

    function automatic logic signed [63:0] f_gain(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
        logic [127:0] n, d;
        n = f_mag(num) << 24;
        d = 128'(den);
        return f_clamp(num < 0, (n + d / 2) / d, 40);
    endfunction

    task automatic predict_item();
        logic signed [63:0] rate, dd, inner, s, k0, k1, y, p00, p01, meas;
        meas = i_angle_measured;
        if (i_opcode == C_OP_LOAD) begin
            ang = meas;
        end else begin
            rate  = f_sat(64'(i_gyro_rate) - bias, 32);
            ang   = f_sat(ang + f_mulr(64'(i_time_step), rate, 16), 32);
            dd    = f_mulr(64'(i_time_step), p_bb, 16);
            inner = dd - p_ab - p_ba + q_angle;
            p_aa  = f_sat(p_aa + f_mulr(64'(i_time_step), inner, 16), 40);
            p_ab  = f_sat(p_ab - dd, 40);
            p_ba  = f_sat(p_ba - dd, 40);
            p_bb  = f_sat(p_bb + f_mulr(q_bias, 64'(i_time_step), 16), 40);
            s = p_aa + r_meas;
            if (s > 0) begin
                k0 = f_gain(p_aa, s);
                k1 = f_gain(p_ba, s);
            end else begin
                k0 = 0;
                k1 = 0;
            end
            y    = meas - ang;
            ang  = f_sat(ang + f_mulr(k0, y, 24), 32);
            bias = f_sat(bias + f_mulr(k1, y, 24), 32);
            // posterior uses the prior aa and ab
            p00  = p_aa;
            p01  = p_ab;
            p_aa = f_sat(p00 - f_mulr(k0, p00, 24), 40);
            p_ab = f_sat(p01 - f_mulr(k0, p01, 24), 40);
            p_ba = f_sat(p_ba - f_mulr(k1, p00, 24), 40);
            p_bb = f_sat(p_bb - f_mulr(k1, p01, 24), 40);
            last_rate = rate;
        end
        angle_q.push_back(ang[31:0]);
        rate_q.push_back(last_rate[31:0]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            q_angle   = 64'(C_RST_ANGLE_NOISE);
            q_bias    = 64'(C_RST_BIAS_NOISE);
            r_meas    = 64'(C_RST_MEAS_NOISE);
            ang       = 0;
            bias      = 0;
            last_rate = 0;
            p_aa      = 64'(C_COV_ONE);
            p_ab      = 0;
            p_ba      = 0;
            p_bb      = 64'(C_COV_ONE);
            angle_q.delete();
            rate_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    C_REG_ANGLE_NOISE: q_angle = 64'(i_cfg_data);
                    C_REG_BIAS_NOISE:  q_bias  = 64'(i_cfg_data);
                    C_REG_MEAS_NOISE:  r_meas  = 64'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (angle_q.size() == 0) begin
                    $display("%0t unexpected result beat angle %0d rate %0d", $time,
                             i_angle_estimate, i_corrected_rate);
                    o_errors++;
                end else begin
                    if (i_angle_estimate !== angle_q[0]) begin
                        $display("%0t angle_estimate expected %0d got %0d", $time,
                                 angle_q[0], i_angle_estimate);
                        o_errors++;
                    end
                    if (i_corrected_rate !== rate_q[0]) begin
                        $display("%0t corrected_rate expected %0d got %0d", $time,
                                 rate_q[0], i_corrected_rate);
                        o_errors++;
                    end
                    void'(angle_q.pop_front());
                    void'(rate_q.pop_front());
                end
            end
            if (i_valid && i_ready_in) predict_item();
        end
        o_pending = angle_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

endmodule

>>> tb/tb_angle_bias_kalman_filter_unit.sv
// testbench top for the angle/bias kalman filter: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module tb_angle_bias_kalman_filter_unit;
    import abkf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_opcode = C_OP_UPDATE;
    logic signed [31:0] i_angle_measured = '0;
    logic signed [31:0] i_gyro_rate = '0;
    logic [15:0]        i_time_step = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_angle_estimate;
    logic signed [31:0] o_corrected_rate;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = C_REG_ANGLE_NOISE;
    logic [23:0]        i_cfg_data = '0;

    int  errors, pending;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    angle_bias_kalman_filter_unit u_dut (.*);

    abkf_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_ready_in       (o_ready),
        .i_opcode         (i_opcode),
        .i_angle_measured (i_angle_measured),
        .i_gyro_rate      (i_gyro_rate),
        .i_time_step      (i_time_step),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_angle_estimate (o_angle_estimate),
        .i_corrected_rate (o_corrected_rate),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        return $urandom_range(0, 3);
    endfunction

    // result side: random stalls, one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_angle_bias_kalman_filter_unit: errors");
            $finish;
        end
    end

    task automatic send_beat(input logic op, input logic [31:0] meas, input logic [31:0] gyro,
                             input logic [15:0] dt);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_opcode         <= op;
        i_angle_measured <= meas;
        i_gyro_rate      <= gyro;
        i_time_step      <= dt;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_noise(input logic [23:0] qa, input logic [23:0] qb, input logic [23:0] r);
        cfg_write(C_REG_ANGLE_NOISE, qa);
        cfg_write(C_REG_BIAS_NOISE, qb);
        cfg_write(C_REG_MEAS_NOISE, r);
    endtask

    // mostly plausible imu samples, some loads and some fully random noise
    task automatic random_beats(input int count);
        logic        op;
        logic [31:0] meas, gyro;
        logic [15:0] dt;
        for (int n = 0; n < count; n++) begin
            op   = ($urandom_range(0, 9) == 0) ? C_OP_LOAD : C_OP_UPDATE;
            meas = 32'($signed($urandom_range(0, 11796480)) - 5898240);
            gyro = 32'($signed($urandom_range(0, 65536000)) - 32768000);
            dt   = 16'($urandom_range(0, 1300));
            if ($urandom_range(0, 4) == 0) begin
                meas = $urandom;
                gyro = $urandom;
                dt   = 16'($urandom);
            end
            if (hold_req == 1'b0 && n == count / 2) hold_req = 1'b1;
            send_beat(op, meas, gyro, dt);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, both opcodes, zero step, saturating inputs
        send_beat(C_OP_UPDATE, 32'd0, 32'd0, 16'd0);
        send_beat(C_OP_UPDATE, 32'h0001_0000, 32'h0002_0000, 16'd655);
        send_beat(C_OP_LOAD, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
        send_beat(C_OP_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
        send_beat(C_OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 16'hffff);
        send_beat(C_OP_LOAD, 32'h8000_0000, 32'h7fff_ffff, 16'd0);
        send_beat(C_OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        send_beat(C_OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 16'd1);
        send_beat(C_OP_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 16'd0);
        send_beat(C_OP_LOAD, 32'd0, 32'd0, 16'd0);
        for (int n = 0; n < 10; n++)
            send_beat(C_OP_UPDATE, $urandom, $urandom, 16'hffff);
        drain();

        random_beats(90);
        drain();
        set_noise(24'd0, 24'd0, 24'd1);
        random_beats(100);
        drain();
        set_noise(24'hffffff, 24'hffffff, 24'hffffff);
        random_beats(100);
        drain();
        calm = 1'b1;
        set_noise(24'($urandom), 24'($urandom), 24'($urandom_range(1, 24'hffffff)));
        random_beats(60);
        calm = 1'b0;
        random_beats(40);
        drain();
        set_noise(C_RST_ANGLE_NOISE, C_RST_BIAS_NOISE, C_RST_MEAS_NOISE);
        random_beats(100);
        drain();

        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_angle_bias_kalman_filter_unit: clean");
        end else begin
            $display("tb_angle_bias_kalman_filter_unit: errors");
        end
        $finish;
    end

endmodule
